// ===== hdl/awc_pkg.sv =====
// Shared types and constants for the sliding-window anagram counter.
// Used by every module under hdl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package awc_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int ALPHABET_DEF    = 26;
	localparam int LETTER_W        = 5;
	localparam int TALLY_W         = 32;

	// operation codes
	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_PATTERN = 2'd1;
	localparam logic [1:0] OP_TEXT    = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_PAT_FULL = 2'd1;
	localparam logic [1:0] ST_PAT_LATE = 2'd2;

	typedef struct packed {
		logic [1:0]          operation;
		logic [LETTER_W-1:0] letter;
	} in_item_t;

	typedef struct packed {
		logic               window_full;
		logic               is_match;
		logic [TALLY_W-1:0] match_total;
		logic [1:0]         status;
	} out_item_t;

	// per-item controls broadcast to every histogram cell
	typedef struct packed {
		logic                go;       // item accepted this cycle
		logic                clear;
		logic                pat_inc;  // count letter into pattern
		logic                txt_inc;  // count letter into window
		logic                txt_dec;  // drop oldest letter from window
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] old;
	} hist_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/anagram_window_counter_top.sv =====
// Sliding-window anagram counter, top level. Depends on awc_pkg, awc_hist_cell, awc_delay_cell.
// An accepted item goes through the cell/state update, then the tally/output register.
// Throughput: 1 item per cycle unless the output stalls; every bin cell updates on accept.
// Reset: arst_n clears all counts, lengths, flags and the tally at once; no clearing pass.
// The delay line holds no reset; a slot is read only after it was written since a clear.
`timescale 1ns / 1ps
`default_nettype none

module anagram_window_counter_top #(
	parameter int MAX_PATTERN = awc_pkg::MAX_PATTERN_DEF,
	parameter int ALPHABET    = awc_pkg::ALPHABET_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire awc_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output awc_pkg::out_item_t      result
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int TW = awc_pkg::TALLY_W;

	// ---------------------------------------------------------------
	// handshake: stage 1 is the state update, stage 2 the result register
	// ---------------------------------------------------------------
	logic accept, out_free;
	logic valid_s1;
	logic [1:0] op_s1, status_s1;
	logic full_s1;

	assign out_free   = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	// ---------------------------------------------------------------
	// window bookkeeping
	// ---------------------------------------------------------------
	logic [LW-1:0] plen_q, seen_q, plen_n, seen_n;
	logic          started_q, started_n;
	logic          is_clear, is_pat, is_text;
	logic          plen_nz, full_now, pat_ok, text_go;
	logic [1:0]    status_n;
	logic          full_n;

	assign is_clear = item.operation == awc_pkg::OP_CLEAR;
	assign is_pat   = item.operation == awc_pkg::OP_PATTERN;
	assign is_text  = item.operation == awc_pkg::OP_TEXT;
	assign plen_nz  = plen_q != '0;
	assign full_now = plen_nz && (seen_q == plen_q);
	// out-of-range pattern letters are dropped silently
	assign pat_ok   = is_pat && !started_q && (plen_q != LW'(MAX_PATTERN)) &&
	                  (int'(item.letter) < ALPHABET);
	// with an empty pattern, text only marks that text has begun
	assign text_go  = is_text && plen_nz;

	always_comb begin
		plen_n    = plen_q;
		seen_n    = seen_q;
		started_n = started_q;
		status_n  = awc_pkg::ST_OK;
		if (is_clear) begin
			plen_n    = '0;
			seen_n    = '0;
			started_n = 1'b0;
		end else begin
			if (is_pat) begin
				if (started_q) status_n = awc_pkg::ST_PAT_LATE;
				else if (plen_q == LW'(MAX_PATTERN)) status_n = awc_pkg::ST_PAT_FULL;
			end
			if (pat_ok) plen_n = plen_q + LW'(1);
			if (is_text) started_n = 1'b1;
			if (text_go) seen_n = full_now ? plen_q : seen_q + LW'(1);
		end
		full_n = (plen_n != '0) && (seen_n == plen_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			seen_q    <= '0;
			started_q <= 1'b0;
			valid_s1  <= 1'b0;
			full_s1   <= 1'b0;
		end else if (accept) begin
			plen_q    <= plen_n;
			seen_q    <= seen_n;
			started_q <= started_n;
			valid_s1  <= 1'b1;
			full_s1   <= full_n;
		end else if (out_free) begin
			valid_s1  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= item.operation;
			status_s1 <= status_n;
		end
	end

	// ---------------------------------------------------------------
	// delay line: letters enter at slot plen-1 and march toward slot 0,
	// so once the window is full slot 0 holds the letter leaving it
	// ---------------------------------------------------------------
	logic [awc_pkg::LETTER_W-1:0] slot [MAX_PATTERN];
	logic                         shift;

	assign shift = accept && text_go;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_slot
		logic [awc_pkg::LETTER_W-1:0] nxt;
		if (i == MAX_PATTERN - 1) begin : g_end
			assign nxt = item.letter;
		end else begin : g_mid
			assign nxt = slot[i+1];
		end
		awc_delay_cell u_slot (
			.clk        (clk),
			.shift      (shift),
			.load       (plen_q == LW'(i + 1)),
			.new_letter (item.letter),
			.next_letter(nxt),
			.letter     (slot[i])
		);
	end

	// ---------------------------------------------------------------
	// histogram bins, one cell per letter
	// ---------------------------------------------------------------
	awc_pkg::hist_ctl_t ctl;
	logic [ALPHABET-1:0] eq;

	always_comb begin
		ctl.go      = accept;
		ctl.clear   = is_clear;
		ctl.pat_inc = pat_ok;
		ctl.txt_inc = text_go;
		ctl.txt_dec = text_go && full_now;
		ctl.letter  = item.letter;
		ctl.old     = slot[0];
	end

	for (genvar b = 0; b < ALPHABET; b++) begin : g_bin
		awc_hist_cell #(
			.BIN    (b),
			.COUNT_W(LW)
		) u_bin (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.eq    (eq[b])
		);
	end

	// ---------------------------------------------------------------
	// stage 2: match, saturating tally, result register
	// ---------------------------------------------------------------
	logic          match_s1;
	logic [TW-1:0] tally_q, tally_n;

	assign match_s1 = full_s1 && (&eq);

	always_comb begin
		tally_n = tally_q;
		if (op_s1 == awc_pkg::OP_CLEAR) tally_n = '0;
		else if (op_s1 == awc_pkg::OP_TEXT && match_s1 && tally_q != '1)
			tally_n = tally_q + TW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q      <= '0;
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= valid_s1;
			if (valid_s1) tally_q <= tally_n;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			result.window_full <= full_s1;
			result.is_match    <= match_s1;
			result.match_total <= tally_n;
			result.status      <= status_s1;
		end
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_match_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.is_match || result.window_full))
		else $error("match reported on a window that is not full");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid))
		else $error("input stalled with an empty pipeline");

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= plen_q)
		else $error("window holds more letters than the pattern length");

	a_tally_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(out_free && valid_s1 && op_s1 != awc_pkg::OP_CLEAR) |=> (tally_q >= $past(tally_q)))
		else $error("match tally decreased without a clear");

	a_len_frozen_after_text: assert property (@(posedge clk) disable iff (!arst_n)
		(started_q && !(accept && is_clear)) |=> $stable(plen_q))
		else $error("pattern length changed after text began");

endmodule

`default_nettype wire

// ===== hdl/awc_hist_cell.sv =====
// One histogram bin: pattern count, window count and their equality flag.
// Depends on awc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module awc_hist_cell #(
	parameter int BIN     = 0,
	parameter int COUNT_W = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire awc_pkg::hist_ctl_t ctl,
	output logic                   eq
);

	localparam int  LW        = awc_pkg::LETTER_W;
	localparam bit  REACHABLE = BIN < (1 << LW);
	localparam logic [LW-1:0] BIN_CODE = LW'(BIN);

	logic [COUNT_W-1:0] p_q, w_q, p_n, w_n;
	logic               eq_q;
	logic               hit_new, hit_old, inc, dec;

	assign hit_new = REACHABLE && (ctl.letter == BIN_CODE);
	assign hit_old = REACHABLE && (ctl.old == BIN_CODE);
	assign inc     = ctl.txt_inc && hit_new;
	assign dec     = ctl.txt_dec && hit_old && (w_q != '0);

	always_comb begin
		p_n = p_q;
		w_n = w_q;
		if (ctl.clear) begin
			p_n = '0;
			w_n = '0;
		end else begin
			if (ctl.pat_inc && hit_new) p_n = p_q + COUNT_W'(1);
			if (inc && !dec) w_n = w_q + COUNT_W'(1);
			else if (dec && !inc) w_n = w_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q  <= '0;
			w_q  <= '0;
			eq_q <= 1'b1;
		end else if (ctl.go) begin
			p_q  <= p_n;
			w_q  <= w_n;
			eq_q <= (p_n == w_n);
		end
	end

	assign eq = eq_q;

endmodule

`default_nettype wire

// ===== hdl/awc_delay_cell.sv =====
// One slot of the window delay line; shifts toward slot 0 or loads the new letter.
// Depends on awc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module awc_delay_cell (
	input  wire logic                          clk,
	input  wire logic                          shift,
	input  wire logic                          load,
	input  wire logic [awc_pkg::LETTER_W-1:0]  new_letter,
	input  wire logic [awc_pkg::LETTER_W-1:0]  next_letter,
	output logic      [awc_pkg::LETTER_W-1:0]  letter
);

	logic [awc_pkg::LETTER_W-1:0] letter_q;

	always_ff @(posedge clk) begin
		if (shift) letter_q <= load ? new_letter : next_letter;
	end

	assign letter = letter_q;

endmodule

`default_nettype wire
